// File: src/cpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex polygon classifier package
// Shared types and constants for the classifier front end, queue and back end.
// ----------------------------------------------------------------------------
package cpc_pkg;

	// Width of the coordinate fields on the vertex port.
	localparam int FIELD_WIDTH = 32;

	// Checks carried by one job: the running triple and the two wrap-around triples.
	localparam int LANES = 3;

	// Entries in the queue between front and back end.
	localparam int QUEUE_DEPTH = 2;

	// Reversal count saturates here, and more than REV_LIMIT reversals fail the polygon.
	localparam logic [1:0] REV_SAT   = 2'd3;
	localparam logic [1:0] REV_LIMIT = 2'd2;

	// Sign values used for direction and turn.
	typedef logic signed [1:0] sign_t;
	localparam sign_t SIGN_NEG  = -2'sd1;
	localparam sign_t SIGN_ZERO = 2'sd0;
	localparam sign_t SIGN_POS  = 2'sd1;

	typedef enum logic [1:0] {
		CLASS_CCW        = 2'd0,
		CLASS_CW         = 2'd1,
		CLASS_NOT_CONVEX = 2'd2
	} class_t;

	// Control part of a job passed from the front end to the back end.
	typedef struct packed {
		logic tri_en;   // the running triple is checked
		logic wrap_en;  // the two wrap-around triples are checked
		logic last;     // closing vertex: a class is produced
	} cpc_ctl_t;

endpackage

// File: src/cpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classifier front end
// Keeps the vertex history and turns each vertex into a job of up to three
// triple checks, each with its lexicographic direction and cross-product terms.
// ----------------------------------------------------------------------------
module cpc_front import cpc_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	localparam int DW = COORD_WIDTH + 1,
	localparam int LANE_W = 4 * DW + 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              vertex_valid,
	output logic                              vertex_ready,
	input  logic signed [FIELD_WIDTH-1:0]     point_x,
	input  logic signed [FIELD_WIDTH-1:0]     point_y,
	input  logic                              last,
	output logic                              job_valid,
	input  logic                              job_ready,
	output cpc_ctl_t                          job_ctl,
	output logic [LANES*LANE_W-1:0]           job_geo
);

	logic signed [COORD_WIDTH-1:0] vx, vy;
	logic signed [COORD_WIDTH-1:0] first_x_q, first_y_q, second_x_q, second_y_q;
	logic signed [COORD_WIDTH-1:0] older_x_q, older_y_q, newer_x_q, newer_y_q;
	logic [1:0] seen_q;
	logic accept;

	// Lexicographic sign of q minus r and the four differences of the cross product
	// (p.x - q.x) * (q.y - r.y) - (p.y - q.y) * (q.x - r.x).
	function automatic logic [LANE_W-1:0] lane_geo(
		input logic signed [COORD_WIDTH-1:0] px, py, qx, qy, rx, ry);
		logic [DW-1:0] a, b, c, d;
		sign_t dir;
		a = {px[COORD_WIDTH-1], px} - {qx[COORD_WIDTH-1], qx};
		b = {qy[COORD_WIDTH-1], qy} - {ry[COORD_WIDTH-1], ry};
		c = {py[COORD_WIDTH-1], py} - {qy[COORD_WIDTH-1], qy};
		d = {qx[COORD_WIDTH-1], qx} - {rx[COORD_WIDTH-1], rx};
		if (qx < rx) begin
			dir = SIGN_NEG;
		end else if (qx > rx) begin
			dir = SIGN_POS;
		end else if (qy < ry) begin
			dir = SIGN_NEG;
		end else if (qy > ry) begin
			dir = SIGN_POS;
		end else begin
			dir = SIGN_ZERO;
		end
		return {dir, a, b, c, d};
	endfunction

	assign vx = point_x[COORD_WIDTH-1:0];
	assign vy = point_y[COORD_WIDTH-1:0];

	assign vertex_ready = job_ready;
	assign job_valid    = vertex_valid;
	assign accept       = vertex_valid && job_ready;

	always_comb begin
		job_ctl.tri_en  = seen_q[1];
		job_ctl.wrap_en = seen_q[1] && last;
		job_ctl.last    = last;
		// The wrap-around triples see the history as it stands after this vertex.
		job_geo[0*LANE_W +: LANE_W] = lane_geo(older_x_q, older_y_q, newer_x_q, newer_y_q, vx, vy);
		job_geo[1*LANE_W +: LANE_W] = lane_geo(newer_x_q, newer_y_q, vx, vy,
			first_x_q, first_y_q);
		job_geo[2*LANE_W +: LANE_W] = lane_geo(vx, vy, first_x_q, first_y_q,
			second_x_q, second_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			if (last) begin
				seen_q <= '0;
			end else if (seen_q != 2'd3) begin
				seen_q <= seen_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (seen_q == 2'd0) begin
				first_x_q <= vx;
				first_y_q <= vy;
			end
			if (seen_q == 2'd1) begin
				second_x_q <= vx;
				second_y_q <= vy;
			end
			older_x_q <= newer_x_q;
			older_y_q <= newer_y_q;
			newer_x_q <= vx;
			newer_y_q <= vy;
		end
	end

endmodule

// File: src/cpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classifier job queue
// Small first-in first-out buffer that lets front and back end stall apart.
// ----------------------------------------------------------------------------
module cpc_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: src/cpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classifier back end
// Multiplies the cross-product terms of each check, then folds the turn signs
// and directions into the running convexity state and registers the class.
// ----------------------------------------------------------------------------
module cpc_back import cpc_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	localparam int DW = COORD_WIDTH + 1,
	localparam int LANE_W = 4 * DW + 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_valid,
	output logic                    job_ready,
	input  cpc_ctl_t                job_ctl,
	input  logic [LANES*LANE_W-1:0] job_geo,
	output logic [1:0]              polygon_class,
	output logic                    class_valid,
	input  logic                    class_ready
);

	localparam int PW = 2 * DW;

	logic signed [PW-1:0] mul_a [LANES];
	logic signed [PW-1:0] mul_b [LANES];

	logic                 valid_s1;
	cpc_ctl_t             ctl_s1;
	logic signed [PW-1:0] prod_a_s1 [LANES];
	logic signed [PW-1:0] prod_b_s1 [LANES];
	sign_t                dir_s1 [LANES];

	sign_t      dir_q, turn_q, dir_n, turn_n;
	logic [1:0] rev_q, rev_n;
	logic       fail_q, fail_n;
	class_t     cls;
	class_t     class_q;
	logic       class_valid_q;
	logic       s1_fire, s1_load;

	for (genvar l = 0; l < LANES; l++) begin : g_mul
		logic signed [DW-1:0] a, b, c, d;
		assign a = job_geo[l*LANE_W + 3*DW +: DW];
		assign b = job_geo[l*LANE_W + 2*DW +: DW];
		assign c = job_geo[l*LANE_W + 1*DW +: DW];
		assign d = job_geo[l*LANE_W +: DW];
		assign mul_a[l] = a * b;
		assign mul_b[l] = c * d;
	end

	// A job without a class never waits on the output register.
	assign s1_fire   = valid_s1 && (!ctl_s1.last || !class_valid_q || class_ready);
	assign s1_load   = !valid_s1 || s1_fire;
	assign job_ready = s1_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			ctl_s1 <= job_ctl;
			for (int l = 0; l < LANES; l++) begin
				prod_a_s1[l] <= mul_a[l];
				prod_b_s1[l] <= mul_b[l];
				dir_s1[l]    <= job_geo[l*LANE_W + 4*DW +: 2];
			end
		end
	end

	// The checks of one job are applied in order: running triple, then the
	// triple closing on the first vertex, then the one through the first two.
	always_comb begin
		logic  en;
		sign_t t;
		dir_n  = dir_q;
		turn_n = turn_q;
		rev_n  = rev_q;
		fail_n = fail_q;
		for (int l = 0; l < LANES; l++) begin
			en = (l == 0) ? ctl_s1.tri_en : ctl_s1.wrap_en;
			if (prod_a_s1[l] > prod_b_s1[l]) begin
				t = SIGN_POS;
			end else if (prod_a_s1[l] < prod_b_s1[l]) begin
				t = SIGN_NEG;
			end else begin
				t = SIGN_ZERO;
			end
			if (en) begin
				// Two zero directions in a row also count as a reversal.
				if (dir_s1[l] == -dir_n) begin
					if (rev_n != REV_SAT) begin
						rev_n = rev_n + 2'd1;
					end
					if (rev_n > REV_LIMIT) begin
						fail_n = 1'b1;
					end
				end
				dir_n = dir_s1[l];
				if (t != SIGN_ZERO) begin
					if (t == -turn_n) begin
						fail_n = 1'b1;
					end
					turn_n = t;
				end
			end
		end
		if (!ctl_s1.wrap_en || fail_n) begin
			cls = CLASS_NOT_CONVEX;
		end else if (turn_n == SIGN_POS) begin
			cls = CLASS_CCW;
		end else if (turn_n == SIGN_NEG) begin
			cls = CLASS_CW;
		end else begin
			cls = CLASS_NOT_CONVEX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= SIGN_ZERO;
			turn_q <= SIGN_ZERO;
			rev_q  <= '0;
			fail_q <= 1'b0;
		end else if (s1_fire) begin
			if (ctl_s1.last) begin
				dir_q  <= SIGN_ZERO;
				turn_q <= SIGN_ZERO;
				rev_q  <= '0;
				fail_q <= 1'b0;
			end else begin
				dir_q  <= dir_n;
				turn_q <= turn_n;
				rev_q  <= rev_n;
				fail_q <= fail_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_valid_q <= 1'b0;
		end else if (s1_fire && ctl_s1.last) begin
			class_valid_q <= 1'b1;
		end else if (class_ready) begin
			class_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && ctl_s1.last) begin
			class_q <= cls;
		end
	end

	assign polygon_class = class_q;
	assign class_valid   = class_valid_q;

endmodule

// File: src/convex_polygon_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex polygon classifier
// Classifies a streamed polygon as convex counter-clockwise, convex clockwise
// or not convex.
// ----------------------------------------------------------------------------
// Vertices enter on the vertex channel (point_x, point_y, last) with a
// valid/ready transfer, one per cycle at full rate while the queue has
// room. Only the vertex marked last produces a transfer on the class
// channel, carrying polygon_class: 0 counter-clockwise, 1 clockwise, 2 not
// convex (also for fewer than three vertices or an all-collinear outline).
// The front end turns each vertex into up to three triple checks and pushes
// them into a two-entry queue; the back end multiplies the cross-product
// terms in one stage and folds the signs into the running state in the next.
// The closing vertex passes through the queue and the back-end stage register
// before the class is registered, and the block sustains one vertex per cycle
// while neither the queue nor the back end stalls.
// When the receiver stalls, the finished class waits in the output register
// while the back end and queue keep taking vertices that produce no class;
// vertex_ready drops once the queue is full. Reset clears the vertex count and
// the convexity state, so the next vertex starts a new polygon.
// ----------------------------------------------------------------------------
module convex_polygon_classifier_top import cpc_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vertex_valid,
	output logic                          vertex_ready,
	input  logic signed [FIELD_WIDTH-1:0] point_x,
	input  logic signed [FIELD_WIDTH-1:0] point_y,
	input  logic                          last,
	output logic                          class_valid,
	input  logic                          class_ready,
	output logic [1:0]                    polygon_class
);

	localparam int LANE_W = 4 * (COORD_WIDTH + 1) + 2;
	localparam int GEO_W  = LANES * LANE_W;
	localparam int JOB_W  = $bits(cpc_ctl_t) + GEO_W;

	logic             push_valid, push_ready, pop_valid, pop_ready;
	cpc_ctl_t         push_ctl, pop_ctl;
	logic [GEO_W-1:0] push_geo, pop_geo;
	logic [JOB_W-1:0] pop_data;

	cpc_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_ready (vertex_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.last         (last),
		.job_valid    (push_valid),
		.job_ready    (push_ready),
		.job_ctl      (push_ctl),
		.job_geo      (push_geo)
	);

	cpc_queue #(
		.DATA_W (JOB_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_ctl, push_geo}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign pop_ctl = pop_data[JOB_W-1:GEO_W];
	assign pop_geo = pop_data[GEO_W-1:0];

	cpc_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (pop_valid),
		.job_ready     (pop_ready),
		.job_ctl       (pop_ctl),
		.job_geo       (pop_geo),
		.polygon_class (polygon_class),
		.class_valid   (class_valid),
		.class_ready   (class_ready)
	);

endmodule
